/* sv/gmd_pkg.sv */
// Shared types and constants for the gyro motionless detector.
// Depends on nothing; gmd_axis, gmd_timer and the top level in sv/ use it by scoped names.
`default_nettype none

package gmd_pkg;

  localparam int AXES_DEFAULT = 3;

  localparam int SAMPLE_W = 16;
  localparam int DT_W     = 8;
  localparam int ACCUM_W  = 9;
  localparam int TIMER_W  = 9;
  localparam int STILL_W  = 8;
  localparam int COUNT_W  = 2;
  localparam int INDEX_W  = 2;
  localparam int DATA_W   = 9;

  // |diff| * gain fits in 18 bits; accumulator plus that in 19
  localparam int MAG_W  = 16;
  localparam int STEP_W = 18;
  localparam int SUM_W  = 19;

  localparam int DIFF_GAIN = 3;

  localparam logic [ACCUM_W-1:0] ACCUM_RESET = 9'd500;
  localparam logic [TIMER_W-1:0] TIMER_MAX   = 9'd511;

  localparam logic [ACCUM_W-1:0] CEILING_RESET   = 9'd200;
  localparam logic [ACCUM_W-1:0] THRESHOLD_RESET = 9'd5;
  localparam logic [STILL_W-1:0] STILL_RESET     = 8'd100;

  // configuration register indexes
  localparam logic [INDEX_W-1:0] REG_ACCUM_CEILING      = 2'd0;
  localparam logic [INDEX_W-1:0] REG_ACTIVITY_THRESHOLD = 2'd1;
  localparam logic [INDEX_W-1:0] REG_STILL_TIME_MS      = 2'd2;

  typedef struct packed {
    logic [ACCUM_W-1:0] accum_ceiling;
    logic [ACCUM_W-1:0] activity_threshold;
    logic [STILL_W-1:0] still_time_ms;
  } cfg_t;

endpackage

`default_nettype wire

/* sv/gmd_axis.sv */
// One axis lane: previous sample, leaky activity accumulator and its update.
// Depends on gmd_pkg.
`default_nettype none

module gmd_axis (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                update,
  input  wire logic signed [gmd_pkg::SAMPLE_W-1:0] sample,
  input  wire logic        [gmd_pkg::DT_W-1:0]     dt,
  input  wire gmd_pkg::cfg_t                       cfg,
  output logic                                     active
);

  logic signed [gmd_pkg::SAMPLE_W-1:0] prev_sample;
  logic        [gmd_pkg::ACCUM_W-1:0]  accum;
  logic        [gmd_pkg::ACCUM_W-1:0]  accum_next;

  logic signed [gmd_pkg::SAMPLE_W:0] diff;
  logic        [gmd_pkg::MAG_W-1:0]  mag;
  logic        [gmd_pkg::STEP_W-1:0] step;
  logic        [gmd_pkg::SUM_W-1:0]  sum;
  logic        [gmd_pkg::SUM_W-1:0]  leaked;

  always_comb begin
    diff = {sample[gmd_pkg::SAMPLE_W-1], sample}
         - {prev_sample[gmd_pkg::SAMPLE_W-1], prev_sample};
    mag  = diff[gmd_pkg::SAMPLE_W] ? gmd_pkg::MAG_W'(-diff)
                                   : diff[gmd_pkg::MAG_W-1:0];
    step = gmd_pkg::STEP_W'(mag * gmd_pkg::DIFF_GAIN);
    sum  = gmd_pkg::SUM_W'(accum) + gmd_pkg::SUM_W'(step);
    leaked = sum - gmd_pkg::SUM_W'(dt);
    // floor at zero, then clamp to ceiling
    if (sum < gmd_pkg::SUM_W'(dt)) begin
      accum_next = '0;
    end else if (leaked > gmd_pkg::SUM_W'(cfg.accum_ceiling)) begin
      accum_next = cfg.accum_ceiling;
    end else begin
      accum_next = leaked[gmd_pkg::ACCUM_W-1:0];
    end
    active = accum_next > cfg.activity_threshold;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_sample <= '0;
      accum       <= gmd_pkg::ACCUM_RESET;
    end else if (update) begin
      prev_sample <= sample;
      accum       <= accum_next;
    end
  end

endmodule

`default_nettype wire

/* sv/gmd_timer.sv */
// Stillness timer: cleared by any active axis, else adds dt and saturates.
// Depends on gmd_pkg.
`default_nettype none

module gmd_timer (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            update,
  input  wire logic                            any_active,
  input  wire logic [gmd_pkg::DT_W-1:0]        dt,
  input  wire logic [gmd_pkg::STILL_W-1:0]     still_time_ms,
  output logic                                 motionless
);

  logic [gmd_pkg::TIMER_W-1:0] timer;
  logic [gmd_pkg::TIMER_W-1:0] timer_next;
  logic [gmd_pkg::TIMER_W:0]   timer_sum;

  always_comb begin
    timer_sum = (gmd_pkg::TIMER_W+1)'(timer) + (gmd_pkg::TIMER_W+1)'(dt);
    if (any_active) begin
      timer_next = '0;
    end else if (timer_sum > (gmd_pkg::TIMER_W+1)'(gmd_pkg::TIMER_MAX)) begin
      timer_next = gmd_pkg::TIMER_MAX;
    end else begin
      timer_next = timer_sum[gmd_pkg::TIMER_W-1:0];
    end
    motionless = timer_next > gmd_pkg::TIMER_W'(still_time_ms);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      timer <= '0;
    end else if (update) begin
      timer <= timer_next;
    end
  end

endmodule

`default_nettype wire

/* sv/gyro_motionless_detector.sv */
// Gyro motionless detector: input register, per-axis lanes, stillness timer,
// result register. An input transaction loads the input register; the item
// then moves on into the result register, where it is presented as valid.
// Throughput one transaction per cycle; the only thing that holds the input
// back is a stalled, full result register.
// Reset (rst, synchronous): pipeline empty, accumulators 500, samples and
// timer 0, registers at ceiling 200, threshold 5, still time 100 ms.
`default_nettype none

module gyro_motionless_detector #(
  parameter int AXES = gmd_pkg::AXES_DEFAULT  // 1..3; lanes use gyro_x, _y, _z in order
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // sample channel
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic signed [gmd_pkg::SAMPLE_W-1:0] gyro_x,
  input  wire logic signed [gmd_pkg::SAMPLE_W-1:0] gyro_y,
  input  wire logic signed [gmd_pkg::SAMPLE_W-1:0] gyro_z,
  input  wire logic        [gmd_pkg::DT_W-1:0]     dt_ms,
  // result channel
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic                                     motionless,
  output logic             [gmd_pkg::COUNT_W-1:0]  active_axes,
  // configuration write channel
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic        [gmd_pkg::INDEX_W-1:0]  cfg_index,
  input  wire logic        [gmd_pkg::DATA_W-1:0]   cfg_data
);

  // ---------------------------------------------------------------------
  // Configuration registers. Writes are always taken; an index past the
  // register list is dropped.
  // ---------------------------------------------------------------------
  gmd_pkg::cfg_t cfg;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.accum_ceiling      <= gmd_pkg::CEILING_RESET;
      cfg.activity_threshold <= gmd_pkg::THRESHOLD_RESET;
      cfg.still_time_ms      <= gmd_pkg::STILL_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        gmd_pkg::REG_ACCUM_CEILING:      cfg.accum_ceiling      <= cfg_data;
        gmd_pkg::REG_ACTIVITY_THRESHOLD: cfg.activity_threshold <= cfg_data;
        gmd_pkg::REG_STILL_TIME_MS: begin
          cfg.still_time_ms <= cfg_data[gmd_pkg::STILL_W-1:0];
        end
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Handshake. Stage 1 is the input register; it drains into the result
  // register whenever that register is empty or being taken this cycle.
  // State (samples, accumulators, timer) updates on that same edge, so the
  // next item in stage 1 already sees it: no bubble needed.
  // ---------------------------------------------------------------------
  logic s1_valid;
  logic advance;   // result register can load
  logic take;      // input transaction this cycle
  logic fire;      // stage 1 item processed this cycle

  assign advance  = !out_valid || !out_stall;
  assign in_stall = s1_valid && !advance;
  assign take     = in_valid && !in_stall;
  assign fire     = s1_valid && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (take || fire) begin
      s1_valid <= take;
    end
  end

  // input payload register
  logic signed [gmd_pkg::SAMPLE_W-1:0] s1_gyro [AXES];
  logic        [gmd_pkg::DT_W-1:0]     s1_dt;
  logic        [AXES-1:0]              lane_active;

  always_ff @(posedge clk) begin
    if (take) begin
      s1_dt <= dt_ms;
    end
  end

  genvar g;
  generate
    for (g = 0; g < AXES; g++) begin : g_lane
      logic signed [gmd_pkg::SAMPLE_W-1:0] lane_in;

      assign lane_in = (g == 0) ? gyro_x : (g == 1) ? gyro_y : gyro_z;

      always_ff @(posedge clk) begin
        if (take) begin
          s1_gyro[g] <= lane_in;
        end
      end

      gmd_axis u_axis (
        .clk    (clk),
        .rst    (rst),
        .update (fire),
        .sample (s1_gyro[g]),
        .dt     (s1_dt),
        .cfg    (cfg),
        .active (lane_active[g])
      );
    end
  endgenerate

  // count of moving axes for this item
  logic [gmd_pkg::COUNT_W-1:0] active_count;

  always_comb begin
    active_count = '0;
    for (int i = 0; i < AXES; i++) begin
      active_count = active_count + gmd_pkg::COUNT_W'(lane_active[i]);
    end
  end

  logic motionless_next;

  gmd_timer u_timer (
    .clk           (clk),
    .rst           (rst),
    .update        (fire),
    .any_active    (|lane_active),
    .dt            (s1_dt),
    .still_time_ms (cfg.still_time_ms),
    .motionless    (motionless_next)
  );

  // ---------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      motionless  <= motionless_next;
      active_axes <= active_count;
    end
  end

endmodule

`default_nettype wire

/* sv/gmd_checker.sv */
// Port-level checks for gyro_motionless_detector, attached with bind.
// Depends on the top level's port list only.
`default_nettype none

module gmd_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_stall,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic       motionless,
  input wire logic [1:0] active_axes
);

  // a stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(motionless) && $stable(active_axes))
    else $error("stalled result changed");

  // any moving axis clears the timer, so motionless implies no active axis
  assert property (@(posedge clk) disable iff (rst)
    out_valid && motionless |-> active_axes == 2'd0)
    else $error("motionless reported with active axes");

  // input is only held back by a blocked result
  assert property (@(posedge clk) disable iff (rst)
    !out_stall |-> !in_stall)
    else $error("input stalled while output is free");

  // reset empties the pipeline
  assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind gyro_motionless_detector gmd_checker u_gmd_checker (
  .clk         (clk),
  .rst         (rst),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .motionless  (motionless),
  .active_axes (active_axes)
);

`default_nettype wire

/* tb/tb_gyro_motionless_detector.sv */
// Testbench for gyro_motionless_detector: random and directed gyro samples with
// random idling on both channels, checked against an in-bench stillness model.
// Depends on gmd_pkg (sv/gmd_pkg.sv) and the detector RTL.
`timescale 1ns / 1ps

module tb_gyro_motionless_detector;
  import gmd_pkg::*;

  localparam int CLK_PERIOD   = 12;
  localparam int RESET_CYCLES = 12;
  localparam int LIMIT_CYCLES = 100000;
  localparam int SETTLE       = 6;     // pipeline is 2 deep; the rest is spare margin
  localparam int LONG_HOLD    = 64;

  // detector arithmetic, kept independent of the RTL package
  localparam int ACTIVITY_GAIN  = 3;
  localparam int ACCUM_AT_RESET = 500;
  localparam int TIMER_SAT      = 511;

  // index 3 decodes to no register; writes there must be dropped
  localparam logic [INDEX_W-1:0] REG_NONE = 2'd3;

  typedef struct packed {
    logic [SAMPLE_W-1:0] x;
    logic [SAMPLE_W-1:0] y;
    logic [SAMPLE_W-1:0] z;
    logic [DT_W-1:0]     dt;
  } sample_t;

  typedef struct packed {
    logic               motionless;
    logic [COUNT_W-1:0] active_axes;
  } result_t;

  // ---------------------------------------------------------------- DUT I/O
  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [SAMPLE_W-1:0] gyro_x = '0;
  logic [SAMPLE_W-1:0] gyro_y = '0;
  logic [SAMPLE_W-1:0] gyro_z = '0;
  logic [DT_W-1:0]     dt_ms = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic                motionless;
  logic [COUNT_W-1:0]  active_axes;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [INDEX_W-1:0]  cfg_index = '0;
  logic [DATA_W-1:0]   cfg_data = '0;

  gyro_motionless_detector uut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .gyro_x      (gyro_x),
    .gyro_y      (gyro_y),
    .gyro_z      (gyro_z),
    .dt_ms       (dt_ms),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .motionless  (motionless),
    .active_axes (active_axes),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always begin
    clk = 1'b0;
    #(CLK_PERIOD / 2);
    clk = 1'b1;
    #(CLK_PERIOD / 2);
  end

  // ------------------------------------------------------- bench-side state
  sample_t sample_backlog[$];    // samples waiting for the driver
  result_t pending_results[$];   // predicted results, oldest first
  sample_t walk_pos = '0;        // last generated sample, seeds the random walk
  int      send_idle_pct = 0;
  int      recv_stall_pct = 0;
  int      fail_count = 0;
  logic    holding = 1'b0;       // long receiver hold-off in progress
  event    hold_kick;

  // stillness model: its own copy of the registers and detector state
  logic [ACCUM_W-1:0]         ceil_reg;
  logic [ACCUM_W-1:0]         thr_reg;
  logic [STILL_W-1:0]         still_reg;
  logic signed [SAMPLE_W-1:0] last_rate [3];
  logic [ACCUM_W-1:0]         activity [3];
  logic [TIMER_W-1:0]         still_ms;

  task automatic reset_model();
    ceil_reg  = 9'd200;
    thr_reg   = 9'd5;
    still_reg = 8'd100;
    for (int a = 0; a < 3; a++) begin
      last_rate[a] = '0;
      activity[a]  = ACCUM_W'(ACCUM_AT_RESET);
    end
    still_ms = '0;
  endtask

  // Advance the model by one accepted sample and return the result it owes.
  function automatic result_t predict_stillness(sample_t s);
    logic signed [SAMPLE_W-1:0] rate [3];
    int      change;
    int      level;
    int      moving;
    int      tsum;
    result_t r;
    rate[0] = s.x;
    rate[1] = s.y;
    rate[2] = s.z;
    moving  = 0;
    for (int a = 0; a < 3; a++) begin
      // full-precision sum, so a 65535 swing times 3 cannot wrap
      change = int'(rate[a]) - int'(last_rate[a]);
      if (change < 0) change = -change;
      level = int'(activity[a]) + ACTIVITY_GAIN * change - int'(s.dt);
      if (level < 0) level = 0;
      // also pulls a leftover above a lowered ceiling back down
      if (level > int'(ceil_reg)) level = int'(ceil_reg);
      activity[a]  = ACCUM_W'(level);
      if (activity[a] > thr_reg) moving++;
      last_rate[a] = rate[a];
    end
    if (moving != 0) begin
      still_ms = '0;
    end else begin
      tsum = int'(still_ms) + int'(s.dt);
      if (tsum > TIMER_SAT) tsum = TIMER_SAT;
      still_ms = TIMER_W'(tsum);
    end
    r.motionless  = (still_ms > TIMER_W'(still_reg));
    r.active_axes = COUNT_W'(moving);
    return r;
  endfunction

  // ------------------------------------------------------------- sample driver
  // Predicts on each accepted transaction, then offers the next queued
  // sample unless it rolls an idle cycle. A stalled offer is held as is.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        pending_results.push_back(predict_stillness({gyro_x, gyro_y, gyro_z, dt_ms}));
      end
      if (!in_valid || !in_stall) begin
        if (sample_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          gyro_x   <= sample_backlog[0].x;
          gyro_y   <= sample_backlog[0].y;
          gyro_z   <= sample_backlog[0].z;
          dt_ms    <= sample_backlog[0].dt;
          in_valid <= 1'b1;
          void'(sample_backlog.pop_front());
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ------------------------------------------------------------ result monitor
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          $error("result with nothing pending: motionless %0d active_axes %0d",
                 motionless, active_axes);
          fail_count++;
        end else begin
          if (motionless !== pending_results[0].motionless) begin
            $error("motionless: expected %0d, got %0d",
                   pending_results[0].motionless, motionless);
            fail_count++;
          end
          if (active_axes !== pending_results[0].active_axes) begin
            $error("active_axes: expected %0d, got %0d",
                   pending_results[0].active_axes, active_axes);
            fail_count++;
          end
          void'(pending_results.pop_front());
        end
      end
      out_stall <= holding || ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // Long hold-off on the result side, counted here; the sender keeps
  // offering so the pipeline fills and in_stall has to rise.
  always begin
    @(hold_kick);
    holding <= 1'b1;
    repeat (LONG_HOLD) @(posedge clk);
    holding <= 1'b0;
  end

  // ------------------------------------------------------------ stimulus
  task automatic push_sample(input logic [SAMPLE_W-1:0] x, y, z,
                             input logic [DT_W-1:0] dt);
    sample_t s;
    s.x  = x;
    s.y  = y;
    s.z  = z;
    s.dt = dt;
    sample_backlog.push_back(s);
  endtask

  function automatic logic [SAMPLE_W-1:0] nudge(logic [SAMPLE_W-1:0] v, int span);
    return v + SAMPLE_W'($urandom_range(0, 2 * span)) - SAMPLE_W'(span);
  endfunction

  // Mostly a slow random walk (what lets the timer run and motionless
  // show), some single-axis jerks, and some fully random samples.
  task automatic queue_random(input int count);
    sample_t s;
    int      pick;
    for (int n = 0; n < count; n++) begin
      s    = walk_pos;
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        if ($urandom_range(0, 2) == 0) s.x = nudge(s.x, 3);
        if ($urandom_range(0, 2) == 0) s.y = nudge(s.y, 3);
        if ($urandom_range(0, 2) == 0) s.z = nudge(s.z, 3);
      end else if (pick < 85) begin
        case ($urandom_range(0, 2))
          0:       s.x = nudge(s.x, 40);
          1:       s.y = nudge(s.y, 40);
          default: s.z = nudge(s.z, 40);
        endcase
      end else begin
        s.x = SAMPLE_W'($urandom);
        s.y = SAMPLE_W'($urandom);
        s.z = SAMPLE_W'($urandom);
      end
      s.dt = ($urandom_range(0, 9) == 0) ? DT_W'($urandom_range(0, 255))
                                         : DT_W'($urandom_range(0, 24));
      walk_pos = s;
      sample_backlog.push_back(s);
    end
  endtask

  // Wait until every queued sample is taken and every result is back.
  task automatic drain();
    do @(negedge clk);
    while (sample_backlog.size() != 0 || in_valid || pending_results.size() != 0);
    repeat (SETTLE) @(negedge clk);
  endtask

  // One register write transaction; called at a rising edge, returns at the
  // edge of the handshake with cfg_valid still high.
  task automatic set_reg(input logic [INDEX_W-1:0] idx, input logic [DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk);
    while (!cfg_ready);
    case (idx)
      REG_ACCUM_CEILING:      ceil_reg  = val;
      REG_ACTIVITY_THRESHOLD: thr_reg   = val;
      REG_STILL_TIME_MS:      still_reg = val[STILL_W-1:0];
      default: ;
    endcase
  endtask

  // Only called with the detector drained.
  task automatic configure(input logic [DATA_W-1:0] ceiling, thr, still_word);
    @(posedge clk);
    set_reg(REG_ACCUM_CEILING, ceiling);
    set_reg(REG_NONE, DATA_W'($urandom));
    set_reg(REG_ACTIVITY_THRESHOLD, thr);
    set_reg(REG_STILL_TIME_MS, still_word);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(input int send_pct, recv_pct, count, input bit squeeze);
    @(negedge clk);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    queue_random(count);
    if (squeeze) -> hold_kick;
    drain();
  endtask

  initial begin
    reset_model();
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Directed run at reset register values. First sample clamps the 500
    // reset level down to the ceiling; then full-scale swings, decay to
    // zero, timer saturation, threshold and still-time equality edges.
    @(negedge clk);
    push_sample(16'h0000, 16'h0000, 16'h0000, 8'd0);
    push_sample(16'h8000, 16'h7FFF, 16'h0000, 8'd1);     // -32768 / 32767
    push_sample(16'h7FFF, 16'h8000, 16'h0000, 8'd255);   // 65535 swings
    push_sample(16'h7FFF, 16'h8000, 16'h0000, 8'd255);   // all decay to 0
    push_sample(16'h7FFF, 16'h8000, 16'h0000, 8'd255);
    push_sample(16'h7FFF, 16'h8000, 16'h0000, 8'd255);   // timer saturates
    push_sample(16'h7FFF, 16'h8000, 16'h0000, 8'd0);
    push_sample(16'h7FFF, 16'h8002, 16'h0000, 8'd1);     // y lands on threshold
    push_sample(16'h7FFF, 16'h8004, 16'h0000, 8'd0);     // y crosses it
    push_sample(16'h7FFF, 16'h8004, 16'h0000, 8'd11);
    push_sample(16'h7FFF, 16'h8004, 16'h0000, 8'd89);    // timer equals still time
    push_sample(16'h7FFF, 16'h8004, 16'h0000, 8'd1);     // one past it
    push_sample(16'h7FFE, 16'h8003, 16'h0001, 8'd0);     // small moves, quiet
    push_sample(16'h7FFC, 16'h8001, 16'h0003, 8'd0);     // all three active
    push_sample(16'hFFFF, 16'h0000, 16'h7FFF, 8'd128);
    drain();

    // top of every register: nothing can be active, timer runs free
    configure(9'd511, 9'd511, 9'd255);
    run_phase(24, 88, 100, 1'b0);

    // bottom: ceiling 0 pins accumulators; bit 8 of still data is dropped
    configure(9'd0, 9'd0, 9'h100);
    run_phase(88, 24, 60, 1'b0);

    // mid settings, no idling, with a long result hold-off
    configure(9'd300, 9'd40, 9'd150);
    run_phase(0, 0, 150, 1'b1);

    // lowered ceiling clamps leftovers; zero threshold
    configure(9'd120, 9'd0, 9'd60);
    run_phase(0, 0, 90, 1'b0);

    if (fail_count == 0) begin
      $display("** gyro_motionless_detector: PASSED **");
    end else begin
      $display("** gyro_motionless_detector: FAILED **");
    end
    $finish;
  end

  initial begin
    #(LIMIT_CYCLES * CLK_PERIOD);
    $display("** gyro_motionless_detector: FAILED **");
    $finish;
  end

endmodule
